### hdl/lpbm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helper functions for the lru page buffer manager
// no dependencies; imported by lru_page_buffer_manager_core

package lpbm_pkg;

    // default pool size and the request field widths
    localparam int LPBM_SLOTS = 16;
    localparam int TID_W      = 4;
    localparam int PAGE_W     = 32;
    localparam int PIN_W      = 8;
    localparam int SLOT_W     = 4;
    localparam int CFG_W      = 5;
    localparam int TAG_W      = TID_W + PAGE_W;

    // highest table id that a fetch may name
    localparam logic [7:0] TID_MAX = 8'd10;

    localparam logic [PIN_W-1:0] PIN_MAX   = 8'hFF;
    localparam logic [PIN_W-1:0] PIN_ZERO  = 8'h00;
    localparam logic [PIN_W-1:0] PIN_ONE   = 8'h01;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // apb map: one 32-bit register, word index in paddr[2]
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;

    localparam logic REQ_FETCH   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_UPD,
        ST_L1,
        ST_L2,
        ST_L3,
        ST_FIN
    } state_t;

    typedef enum logic [1:0] {
        OP_HIT,
        OP_FILL,
        OP_EVICT,
        OP_REL
    } op_t;

    typedef struct packed {
        logic             dirty;
        logic [PIN_W-1:0] pins;
    } meta_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              need_read;
        logic              need_writeback;
        logic [TID_W-1:0]  victim_table;
        logic [PAGE_W-1:0] victim_page;
        logic [PIN_W-1:0]  pin_level;
    } result_t;

    function automatic logic [PIN_W-1:0] pin_up(input logic [PIN_W-1:0] p);
        return (p < PIN_MAX) ? p + PIN_ONE : PIN_MAX;
    endfunction

    function automatic logic [PIN_W-1:0] pin_dn(input logic [PIN_W-1:0] p);
        return (p > PIN_ZERO) ? p - PIN_ONE : PIN_ZERO;
    endfunction

endpackage

### hdl/lru_page_buffer_manager_core.sv
`timescale 1ns / 1ps
// lru page buffer manager top level: tag lookup, recency list and apb register
// depends on lpbm_pkg and lpbm_ram

// Tag and replacement manager for a fully associative pool of SLOTS page buffers.
// A fetch word (req_type 0) looks up req_table/req_page among the filled slots;
// a hit moves the slot to the most recently used end and raises its pin count,
// a miss takes the next free slot while fewer than slots_in_use are filled, and
// otherwise evicts the least recently used slot and reports its table, page and
// dirty flag. A release word (req_type 1) lowers a slot's pin count, saturating
// at zero, and can mark it dirty. Fetches with a table id of 0 or above the table
// limit, and releases of unfilled slots, are dropped and give no result word.
// Rate: one request at a time. A release reads the slot's metadata and links,
// writes the new pin count and dirty flag and loads the result register. A fetch
// walks the tag memory one slot per cycle, then reads the slot's metadata and
// links and, unless a hit is already the head, rewrites the links through the
// single write port of each link memory: a hit or an eviction unlinks the slot,
// makes it the head and points the old head back at it; a fill skips the unlink.
// A result word still stalled in the output register holds the next result back
// until it is taken.
// All per-slot state sits in four registered-read rams (tag, pins/dirty, older
// and newer links); no unwritten entry is ever used, so there is no clearing pass
// after reset. Since one request finishes all its writes before the next is
// accepted, no forwarding is needed. The next request is accepted while a
// finished result word still waits in the output register.

module lru_page_buffer_manager_core #(
    parameter int SLOTS = lpbm_pkg::LPBM_SLOTS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                req_type,
    input  logic [lpbm_pkg::TID_W-1:0]          req_table,
    input  logic [lpbm_pkg::PAGE_W-1:0]         req_page,
    input  logic [lpbm_pkg::SLOT_W-1:0]         release_slot,
    input  logic                                set_dirty,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [lpbm_pkg::SLOT_W-1:0]         slot,
    output logic                                hit,
    output logic                                need_read,
    output logic                                need_writeback,
    output logic [lpbm_pkg::TID_W-1:0]          victim_table,
    output logic [lpbm_pkg::PAGE_W-1:0]         victim_page,
    output logic [lpbm_pkg::PIN_W-1:0]          pin_level,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpbm_pkg::APB_AW-1:0]         paddr,
    input  logic [lpbm_pkg::APB_DW-1:0]         pwdata,
    output logic [lpbm_pkg::APB_DW-1:0]         prdata,
    output logic                                pready
);

    import lpbm_pkg::*;

    // slot index width and link width (links also hold the none code SLOTS)
    localparam int SW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam int CW = (LW > CFG_W) ? LW : CFG_W;
    localparam int RW = (LW > SLOT_W) ? LW : SLOT_W;
    localparam logic [LW-1:0] NONE = LW'(SLOTS);

    // control registers
    state_t          state_reg, state_next;
    logic [LW-1:0]   mru_reg, mru_next;
    logic [LW-1:0]   lru_reg, lru_next;
    logic [LW-1:0]   filled_reg, filled_next;
    logic [CFG_W-1:0] cfg_reg;
    logic            out_valid_reg, out_valid_next;
    logic            cmp_valid_reg, cmp_valid_next;

    // request and working registers
    logic [TID_W-1:0]  tid_reg, tid_next;
    logic [PAGE_W-1:0] pn_reg, pn_next;
    logic              dirty_in_reg, dirty_in_next;
    logic [SW-1:0]     s_reg, s_next;
    op_t               op_reg, op_next;
    logic [LW-1:0]     issue_reg, issue_next;
    logic [SW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [LW-1:0]     p_reg, p_next;
    logic [LW-1:0]     n_reg, n_next;
    logic [LW-1:0]     ma_reg, ma_next;
    logic [LW-1:0]     la_reg, la_next;
    result_t           res_reg, res_next;
    result_t           out_reg, out_next;

    // ram ports
    logic              tag_we;
    logic [SW-1:0]     tag_waddr, tag_raddr;
    logic [TAG_W-1:0]  tag_wdata, tag_rdata;
    logic              meta_we;
    logic [SW-1:0]     meta_waddr;
    meta_t             meta_wdata, meta_rdata;
    logic              older_we;
    logic [SW-1:0]     older_waddr;
    logic [LW-1:0]     older_wdata, older_rdata;
    logic              newer_we;
    logic [SW-1:0]     newer_waddr;
    logic [LW-1:0]     newer_wdata, newer_rdata;

    // decode helpers
    logic          in_accept;
    logic          out_free;
    logic          rel_ok;
    logic          tid_ok;
    logic          room;
    logic          scan_match;
    logic          scan_done;
    logic          at_mru;
    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] cap;
    logic          cfg_write;

    lpbm_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .raddr (tag_raddr),
        .rdata (tag_rdata)
    );

    lpbm_ram #(.WIDTH($bits(meta_t)), .DEPTH(SLOTS)) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (s_reg),
        .rdata (meta_rdata)
    );

    // next_older links: toward the lru end
    lpbm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_older_ram (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .raddr (s_reg),
        .rdata (older_rdata)
    );

    // prev_newer links: toward the mru end
    lpbm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_newer_ram (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .raddr (s_reg),
        .rdata (newer_rdata)
    );

    // apb register: slots_in_use
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS_IN_USE);
    assign prdata    = (paddr[2] == REG_SLOTS_IN_USE) ? APB_DW'(cfg_reg) : '0;

    // usable pool size: 0 acts as 1, above SLOTS acts as SLOTS
    assign cfg_ext = CW'(cfg_reg);
    assign cap     = (cfg_ext == '0) ? CW'(1) :
                     ((cfg_ext > CW'(SLOTS)) ? CW'(SLOTS) : cfg_ext);
    assign room    = CW'(filled_reg) < cap;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // release of an unfilled slot is dropped
    assign rel_ok = RW'(release_slot) < RW'(filled_reg);
    assign tid_ok = (req_table != '0) && ({4'd0, req_table} <= TID_MAX);

    // tag walk: address issued one cycle, compared the next
    assign scan_match = cmp_valid_reg && (tag_rdata == {tid_reg, pn_reg});
    assign scan_done  = issue_reg >= filled_reg;
    assign at_mru     = (LW'(s_reg) == mru_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (req_type == REQ_RELEASE)
                    begin
                        state_next = rel_ok ? ST_RD : ST_IDLE;
                    end
                    else
                    begin
                        state_next = tid_ok ? ST_SCAN : ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_match)
                begin
                    state_next = ST_RD;
                end
                else if (scan_done)
                begin
                    // full pool with an empty list cannot evict
                    state_next = (room || (lru_reg != NONE)) ? ST_RD : ST_IDLE;
                end
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if ((op_reg == OP_REL) || ((op_reg == OP_HIT) && at_mru))
                begin
                    state_next = ST_FIN;
                end
                else if (op_reg == OP_FILL)
                begin
                    state_next = ST_L2;
                end
                else
                begin
                    state_next = ST_L1;
                end
            end
            ST_L1:
            begin
                state_next = ST_L2;
            end
            ST_L2:
            begin
                state_next = ST_L3;
            end
            ST_L3:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ram controls
    always_comb
    begin
        tag_we      = 1'b0;
        tag_waddr   = s_reg;
        tag_wdata   = {tid_reg, pn_reg};
        tag_raddr   = (state_reg == ST_SCAN) ? SW'(issue_reg) : s_reg;
        meta_we     = 1'b0;
        meta_waddr  = s_reg;
        meta_wdata  = '{dirty: 1'b0, pins: PIN_ONE};
        older_we    = 1'b0;
        older_waddr = s_reg;
        older_wdata = ma_reg;
        newer_we    = 1'b0;
        newer_waddr = s_reg;
        newer_wdata = NONE;
        case (state_reg)
            ST_UPD:
            begin
                meta_we = 1'b1;
                case (op_reg)
                    OP_REL:
                    begin
                        meta_wdata = '{dirty: meta_rdata.dirty | dirty_in_reg,
                                       pins: pin_dn(meta_rdata.pins)};
                    end
                    OP_HIT:
                    begin
                        meta_wdata = '{dirty: meta_rdata.dirty,
                                       pins: pin_up(meta_rdata.pins)};
                    end
                    default:
                    begin
                        // refilled slot: clean, pinned once
                        tag_we     = 1'b1;
                        meta_wdata = '{dirty: 1'b0, pins: PIN_ONE};
                    end
                endcase
            end
            ST_L1:
            begin
                // unlink: neighbors point past this slot
                older_we    = (p_reg != NONE);
                older_waddr = SW'(p_reg);
                older_wdata = n_reg;
                newer_we    = (n_reg != NONE);
                newer_waddr = SW'(n_reg);
                newer_wdata = p_reg;
            end
            ST_L2:
            begin
                // slot becomes the head
                older_we    = 1'b1;
                older_waddr = s_reg;
                older_wdata = ma_reg;
                newer_we    = 1'b1;
                newer_waddr = s_reg;
                newer_wdata = NONE;
            end
            ST_L3:
            begin
                // old head now points back at this slot
                newer_we    = (ma_reg != NONE);
                newer_waddr = SW'(ma_reg);
                newer_wdata = LW'(s_reg);
            end
            default:
            begin
            end
        endcase
    end

    // working register updates
    always_comb
    begin
        mru_next       = mru_reg;
        lru_next       = lru_reg;
        filled_next    = filled_reg;
        out_valid_next = out_valid_reg;
        cmp_valid_next = cmp_valid_reg;
        tid_next       = tid_reg;
        pn_next        = pn_reg;
        dirty_in_next  = dirty_in_reg;
        s_next         = s_reg;
        op_next        = op_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        ma_next        = ma_reg;
        la_next        = la_reg;
        res_next       = res_reg;
        out_next       = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    tid_next       = req_table;
                    pn_next        = req_page;
                    dirty_in_next  = set_dirty;
                    s_next         = SW'(release_slot);
                    op_next        = OP_REL;
                    issue_next     = '0;
                    cmp_valid_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (scan_match)
                begin
                    s_next  = cmp_idx_reg;
                    op_next = OP_HIT;
                end
                else if (scan_done)
                begin
                    if (room)
                    begin
                        s_next  = SW'(filled_reg);
                        op_next = OP_FILL;
                    end
                    else
                    begin
                        s_next  = SW'(lru_reg);
                        op_next = OP_EVICT;
                    end
                end
                else
                begin
                    cmp_idx_next   = SW'(issue_reg);
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + LW'(1);
                end
            end
            ST_UPD:
            begin
                p_next = newer_rdata;
                n_next = older_rdata;
                if (op_reg == OP_FILL)
                begin
                    ma_next     = mru_reg;
                    la_next     = lru_reg;
                    filled_next = filled_reg + LW'(1);
                end
                else
                begin
                    // list ends after this slot is unlinked
                    ma_next = (newer_rdata != NONE) ? mru_reg : older_rdata;
                    la_next = (older_rdata != NONE) ? lru_reg : newer_rdata;
                end

                res_next                = '0;
                res_next.slot           = SLOT_W'(s_reg);
                case (op_reg)
                    OP_REL:
                    begin
                        res_next.pin_level = pin_dn(meta_rdata.pins);
                    end
                    OP_HIT:
                    begin
                        res_next.hit       = 1'b1;
                        res_next.pin_level = pin_up(meta_rdata.pins);
                    end
                    OP_FILL:
                    begin
                        res_next.need_read = 1'b1;
                        res_next.pin_level = PIN_ONE;
                    end
                    default:
                    begin
                        res_next.need_read      = 1'b1;
                        res_next.need_writeback = meta_rdata.dirty;
                        res_next.victim_table   = tag_rdata[TAG_W-1:PAGE_W];
                        res_next.victim_page    = tag_rdata[PAGE_W-1:0];
                        res_next.pin_level      = PIN_ONE;
                    end
                endcase
            end
            ST_L3:
            begin
                mru_next = LW'(s_reg);
                lru_next = (ma_reg != NONE) ? la_reg : LW'(s_reg);
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mru_reg       <= NONE;
            lru_reg       <= NONE;
            filled_reg    <= '0;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mru_reg       <= mru_next;
            lru_reg       <= lru_next;
            filled_reg    <= filled_next;
            out_valid_reg <= out_valid_next;
            cmp_valid_reg <= cmp_valid_next;
            if (cfg_write)
            begin
                cfg_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        tid_reg      <= tid_next;
        pn_reg       <= pn_next;
        dirty_in_reg <= dirty_in_next;
        s_reg        <= s_next;
        op_reg       <= op_next;
        issue_reg    <= issue_next;
        cmp_idx_reg  <= cmp_idx_next;
        p_reg        <= p_next;
        n_reg        <= n_next;
        ma_reg       <= ma_next;
        la_reg       <= la_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // result word
    assign out_valid      = out_valid_reg;
    assign slot           = out_reg.slot;
    assign hit            = out_reg.hit;
    assign need_read      = out_reg.need_read;
    assign need_writeback = out_reg.need_writeback;
    assign victim_table   = out_reg.victim_table;
    assign victim_page    = out_reg.victim_page;
    assign pin_level      = out_reg.pin_level;

`ifndef NO_ASSERTIONS
    // both list ends are empty together
    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (mru_reg == NONE) == (lru_reg == NONE))
        else $error("mru and lru disagree on an empty list");

    // between requests the list is empty exactly when no slot is filled
    a_empty_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((filled_reg == '0) == (mru_reg == NONE)))
        else $error("list state does not match fill count");

    // a hit reads back the tag it matched
    a_hit_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) && (op_reg == OP_HIT) |->
            (tag_rdata == {tid_reg, pn_reg}))
        else $error("hit slot tag changed before update");

    // the pool fills one slot at a time
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (filled_reg != $past(filled_reg)) |-> (filled_reg == $past(filled_reg) + LW'(1)))
        else $error("fill count jumped");
`endif

endmodule

### hdl/lpbm_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies

module lpbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
